/* hw/rtl/bbfh_pkg.sv */
// Shared types and constants for the bounded back/forward history block.
// Used by bounded_back_forward_history; depends on nothing.
package bbfh_pkg;

   // Ring size and the most entries kept on the back side
   localparam int RING_DEPTH = 32;
   localparam int BACK_LIMIT = 25;

   // Back side can hold at most one entry less than the ring
   localparam int EFF_LIMIT  = (BACK_LIMIT < RING_DEPTH - 1) ? BACK_LIMIT : RING_DEPTH - 1;

   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH);
   localparam int VALUE_W    = 32;

   // Command codes
   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_BACK    = 2'd1;
   localparam logic [1:0] CMD_FORWARD = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] current_value;
      logic               current_valid;
      logic               can_go_back;
      logic               can_go_forward;
      logic               moved;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

/* hw/rtl/bbfh_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module bbfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bounded_back_forward_history.sv */
// Back/forward navigation history kept in a ring RAM, top level.
// Depends on bbfh_pkg and bbfh_ram.
//
//   channel | ports                        | direction | moves
//   --------+------------------------------+-----------+-------------------------------
//   request | req_valid, req_stall, req_data | in      | command and handle to push
//   result  | rsp_valid, rsp_stall, rsp_data | out     | current entry and side flags
//
// Push, empty-side moves and unused codes produce a result from the idle state; a back or
// forward move that changes current passes through the read state for the registered RAM read.
// One request is worked on at a time; results wait in an output register plus a
// skid register, so a request is taken while one result waits downstream.
// Reset is synchronous and clears the cursor, counts and current entry; the ring
// RAM is not cleared (entries are only read after being written).
// The request side stalls during the RAM read and while the skid register is full.
module bounded_back_forward_history
   import bbfh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0]  LIMIT_COUNT = CNT_W'(EFF_LIMIT);

   // History state
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]   back_ff, back_in;
   logic [CNT_W-1:0]   fwd_ff, fwd_in;
   logic               has_cur_ff, has_cur_in;
   logic [VALUE_W-1:0] cur_ff, cur_in;

   // Result registers
   logic    out_v_ff, out_v_in;
   rsp_type out_ff, out_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type skid_ff, skid_in;

   // RAM controls
   logic               ram_we, ram_re;
   logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   logic              accept, produce, take;
   logic [SLOT_W-1:0] slot_next, slot_prev;
   rsp_type           result;

   bbfh_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE) || skid_v_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_v_ff && !rsp_stall;

   // Ring neighbors of the current slot
   assign slot_next = (cursor_ff == LAST_SLOT) ? '0 : cursor_ff + 1'b1;
   assign slot_prev = (cursor_ff == '0) ? LAST_SLOT : cursor_ff - 1'b1;

   // Command decode, state update and RAM access
   always_comb begin
      state_in   = state_ff;
      cursor_in  = cursor_ff;
      back_in    = back_ff;
      fwd_in     = fwd_ff;
      has_cur_in = has_cur_ff;
      cur_in     = cur_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = cursor_ff;
      ram_raddr  = slot_prev;
      produce    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_PUSH: begin
                     if (has_cur_ff) begin
                        cursor_in = slot_next;
                        ram_waddr = slot_next;
                        back_in   = (back_ff == LIMIT_COUNT) ? back_ff : back_ff + 1'b1;
                     end
                     ram_we     = 1'b1;
                     fwd_in     = '0;
                     cur_in     = req_data.value;
                     has_cur_in = 1'b1;
                     produce    = 1'b1;
                  end
                  CMD_BACK: begin
                     if (back_ff != '0) begin
                        cursor_in = slot_prev;
                        ram_raddr = slot_prev;
                        ram_re    = 1'b1;
                        back_in   = back_ff - 1'b1;
                        fwd_in    = fwd_ff + 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        produce = 1'b1;
                     end
                  end
                  CMD_FORWARD: begin
                     if (fwd_ff != '0) begin
                        cursor_in = slot_next;
                        ram_raddr = slot_next;
                        ram_re    = 1'b1;
                        fwd_in    = fwd_ff - 1'b1;
                        back_in   = back_ff + 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        produce = 1'b1;
                     end
                  end
                  default: begin
                     produce = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // Neighbor entry arrives from the ring and becomes current
            cur_in   = ram_rdata;
            produce  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.current_value  = cur_in;
      result.current_valid  = has_cur_in;
      result.can_go_back    = (back_in != '0);
      result.can_go_forward = (fwd_in != '0);
      result.moved          = (state_ff == ST_READ);
   end

   // Output register with skid stage
   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_v_ff || take) begin
            out_in   = result;
            out_v_in = 1'b1;
         end else begin
            skid_in   = result;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cursor_ff  <= '0;
         back_ff    <= '0;
         fwd_ff     <= '0;
         has_cur_ff <= 1'b0;
         cur_ff     <= '0;
         out_v_ff   <= 1'b0;
         skid_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cursor_ff  <= cursor_in;
         back_ff    <= back_in;
         fwd_ff     <= fwd_in;
         has_cur_ff <= has_cur_in;
         cur_ff     <= cur_in;
         out_v_ff   <= out_v_in;
         skid_v_ff  <= skid_v_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // Skid holds a result only behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   // RAM read wait is always followed by the idle state
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("read state held longer than one cycle");

   // Back and forward sides never overlap in the ring
   a_sides_fit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, back_ff} + {1'b0, fwd_ff}) <= (CNT_W + 1)'(RING_DEPTH - 1))
      else $error("back and forward entries exceed ring capacity");

   // Back side stays within its limit
   a_back_limit: assert property (@(posedge clock) disable iff (reset)
      back_ff <= LIMIT_COUNT)
      else $error("back count above limit");

   // A side entry exists only once a current entry exists
   a_sides_need_current: assert property (@(posedge clock) disable iff (reset)
      ((back_ff != '0) || (fwd_ff != '0)) |-> has_cur_ff)
      else $error("history entries without a current entry");

endmodule
